// ===== rtl/core/gpf_pkg.sv =====
// Shared constants, types and the address and size-clamp helpers for the grid peak finder.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package gpf_pkg;

  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLS    = 64;
  localparam int VALUE_BITS  = 16;
  localparam int CELL_W      = 16;
  localparam int SIZE_W      = 7;
  localparam int POS_W       = 6;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int PTR_W       = ADDR_W + 1;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_W       = 7;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

  typedef struct packed {
    logic [SIZE_W-1:0] nr;
    logic [SIZE_W-1:0] nc;
  } gpf_size_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } gpf_res_t;

  // Row-major address of (r, c) for a grid nc columns wide.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [POS_W-1:0]  r,
                                                  input logic [SIZE_W-1:0] c,
                                                  input logic [SIZE_W-1:0] nc);
    logic [PTR_W:0] p;
    p = (PTR_W+1)'(r) * (PTR_W+1)'(nc) + (PTR_W+1)'(c);
    return p[ADDR_W-1:0];
  endfunction

  // Zero acts as one; anything above the maximum saturates.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/gpf_in_if.sv =====
// Input channel of the grid peak finder: one grid element per word.
// Depends on gpf_pkg for field widths.
`timescale 1ns / 1ps

interface gpf_in_if;
  logic                      valid;
  logic                      ready;
  logic [gpf_pkg::CELL_W-1:0] cell_value;
  logic                      last_cell;

  modport source (output valid, output cell_value, output last_cell, input ready);
  modport sink   (input valid, input cell_value, input last_cell, output ready);
endinterface

// ===== rtl/core/gpf_out_if.sv =====
// Result channel of the grid peak finder: one search result per word.
// Depends on gpf_pkg for field widths.
`timescale 1ns / 1ps

interface gpf_out_if;
  logic                      valid;
  logic                      ready;
  logic                      peak_found;
  logic [gpf_pkg::POS_W-1:0] peak_row;
  logic [gpf_pkg::POS_W-1:0] peak_col;

  modport source (output valid, output peak_found, output peak_row, output peak_col,
                  input ready);
  modport sink   (input valid, input peak_found, input peak_row, input peak_col,
                  output ready);
endinterface

// ===== rtl/core/gpf_engine.sv =====
// Grid store and column binary-search sequencer of the grid peak finder.
// Depends on gpf_pkg and gpf_in_if; the grid lives in a RAM with a registered read port here.
`timescale 1ns / 1ps

module gpf_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  gpf_pkg::gpf_size_t size,
  gpf_in_if.sink             in_ch,
  output logic               res_valid,
  input  logic               res_ready,
  output gpf_pkg::gpf_res_t  res
);

  typedef enum logic [7:0] {
    S_LOAD   = 8'b0000_0001,
    S_CHECK  = 8'b0000_0010,
    S_SCAN   = 8'b0000_0100,
    S_FLUSH  = 8'b0000_1000,
    S_LEFT   = 8'b0001_0000,
    S_RIGHT  = 8'b0010_0000,
    S_DECIDE = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } gpf_state_t;

  gpf_state_t state_r, state_nxt;

  logic [gpf_pkg::VALUE_BITS-1:0] mem [gpf_pkg::STORE_DEPTH];
  logic [gpf_pkg::VALUE_BITS-1:0] rd_data_r;
  logic [gpf_pkg::ADDR_W-1:0]     rd_addr;

  logic [gpf_pkg::PTR_W-1:0]  ptr_r;
  logic [gpf_pkg::PTR_W-1:0]  total;
  logic [gpf_pkg::SIZE_W-1:0] lo_r, hi_r;   // hi_r is one past the search high
  logic [gpf_pkg::SIZE_W-1:0] mid_r;
  logic [gpf_pkg::SIZE_W:0]   mid_sum;
  logic [gpf_pkg::POS_W-1:0]  scan_row_r;
  logic                       dval_r;
  logic [gpf_pkg::POS_W-1:0]  drow_r;
  logic [gpf_pkg::POS_W-1:0]  best_row_r;
  logic [gpf_pkg::VALUE_BITS-1:0] best_val_r, left_val_r;
  gpf_pkg::gpf_res_t          res_r;

  logic in_fire, load_en, last_row;
  logic has_left, has_right, gt_left, lt_left, gt_right;

  assign in_ch.ready = (state_r == S_LOAD);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign total       = gpf_pkg::PTR_W'(size.nr) * gpf_pkg::PTR_W'(size.nc);
  assign load_en     = in_fire && (ptr_r < total);
  assign last_row    = (gpf_pkg::SIZE_W'(scan_row_r) == size.nr - gpf_pkg::SIZE_W'(1));
  assign mid_sum     = (gpf_pkg::SIZE_W+1)'(lo_r) + (gpf_pkg::SIZE_W+1)'(hi_r)
                       - (gpf_pkg::SIZE_W+1)'(1);

  // Out-of-grid neighbours count as below every value.
  assign has_left  = (mid_r != '0);
  assign has_right = ((gpf_pkg::SIZE_W+1)'(mid_r) + (gpf_pkg::SIZE_W+1)'(1))
                     < (gpf_pkg::SIZE_W+1)'(size.nc);
  assign gt_left   = !has_left  || (best_val_r > left_val_r);
  assign lt_left   = has_left   && (best_val_r < left_val_r);
  assign gt_right  = !has_right || (best_val_r > rd_data_r);

  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  always_comb begin
    case (state_r)
      S_SCAN:  rd_addr = gpf_pkg::cell_addr(scan_row_r, mid_r, size.nc);
      S_LEFT:  rd_addr = gpf_pkg::cell_addr(best_row_r, mid_r - gpf_pkg::SIZE_W'(1), size.nc);
      S_RIGHT: rd_addr = gpf_pkg::cell_addr(best_row_r, mid_r + gpf_pkg::SIZE_W'(1), size.nc);
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD:   if (in_fire && in_ch.last_cell) state_nxt = S_CHECK;
      S_CHECK:  state_nxt = (lo_r < hi_r) ? S_SCAN : S_DONE;
      S_SCAN:   if (last_row) state_nxt = S_FLUSH;
      S_FLUSH:  state_nxt = S_LEFT;
      S_LEFT:   state_nxt = S_RIGHT;
      S_RIGHT:  state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = (gt_left && gt_right) ? S_DONE : S_CHECK;
      S_DONE:   if (res_ready) state_nxt = S_LOAD;
      default:  state_nxt = S_LOAD;
    endcase
  end

  // Grid RAM: one write port for loading, one registered read port for the search.
  always_ff @(posedge clk) begin
    if (load_en) begin
      mem[ptr_r[gpf_pkg::ADDR_W-1:0]] <= in_ch.cell_value[gpf_pkg::VALUE_BITS-1:0];
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      ptr_r   <= '0;
      lo_r    <= '0;
      hi_r    <= '0;
      dval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dval_r  <= (state_r == S_SCAN);
      if (in_fire) begin
        if (in_ch.last_cell) begin
          ptr_r <= '0;
          lo_r  <= '0;
          hi_r  <= size.nc;
        end else if (load_en) begin
          ptr_r <= ptr_r + gpf_pkg::PTR_W'(1);
        end
      end
      if (state_r == S_DECIDE && !(gt_left && gt_right)) begin
        if (lt_left) begin
          hi_r <= mid_r;
        end else begin
          lo_r <= mid_r + gpf_pkg::SIZE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    drow_r <= scan_row_r;
    if (state_r == S_CHECK) begin
      mid_r      <= mid_sum[gpf_pkg::SIZE_W:1];
      scan_row_r <= '0;
      if (lo_r >= hi_r) begin
        res_r <= '0;
      end
    end else if (state_r == S_SCAN) begin
      scan_row_r <= scan_row_r + gpf_pkg::POS_W'(1);
    end
    // Keep the first row that holds the column maximum.
    if (dval_r && (drow_r == '0 || rd_data_r > best_val_r)) begin
      best_val_r <= rd_data_r;
      best_row_r <= drow_r;
    end
    if (state_r == S_RIGHT) begin
      left_val_r <= rd_data_r;
    end
    if (state_r == S_DECIDE && gt_left && gt_right) begin
      res_r.found <= 1'b1;
      res_r.row   <= best_row_r;
      res_r.col   <= mid_r[gpf_pkg::POS_W-1:0];
    end
  end

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= total)
    else $error("load pointer ran past the grid");

  a_scan_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (gpf_pkg::SIZE_W'(scan_row_r) < size.nr))
    else $error("column scan past the last row");

  a_mid_col: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (mid_r < size.nc))
    else $error("middle column outside the grid");

  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.last_cell) |=> (state_r == S_CHECK && ptr_r == '0))
    else $error("last element did not start the search");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res.found) |-> (res.row == '0 && res.col == '0))
    else $error("failed search carries a position");

endmodule

// ===== rtl/core/grid_peak_finder.sv =====
// Top level of the grid peak finder: configuration registers, size clamp, result register.
// Depends on gpf_pkg, gpf_in_if, gpf_out_if and gpf_engine.
`timescale 1ns / 1ps
//
// Usage:
//   in_ch takes the grid in row-major order, one 16-bit element per word; last_cell
//   marks the final element and starts the search. Elements beyond rows_in_use x
//   cols_in_use are dropped. out_ch delivers one word per last_cell: peak_found and
//   the row and column of the peak (both zero when the search fails).
//   cfg_we/cfg_idx/cfg_wdata write rows_in_use (index 0) or cols_in_use (index 1);
//   write them only while the block is idle. Zero acts as one, above 64 saturates.
// Timing:
//   Loading takes one element per cycle while in_ch.ready is high. The search walks one
//   column per binary-search step, reading the grid RAM one row per cycle and then both
//   neighbours of the column maximum; up to 7 steps run for 64 columns, a failed search
//   adds one closing check, and the done state hands the result to the output register.
//   in_ch.ready is low from the last element until the result is in the output register.
// Reset:
//   Synchronous rst_n sets both sizes to 64, empties the output register and rewinds
//   the load position. The grid RAM is not cleared.
// Stall:
//   The result waits in the output register while out_ch.ready is low; loading of the
//   next grid goes on, and the next search holds its result until the register frees.

module grid_peak_finder (
  input  logic                          clk,
  input  logic                          rst_n,
  gpf_in_if.sink                        in_ch,
  gpf_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [gpf_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [gpf_pkg::CFG_W-1:0]     cfg_wdata
);

  logic [gpf_pkg::SIZE_W-1:0] rows_r, cols_r;
  gpf_pkg::gpf_size_t         size;
  gpf_pkg::gpf_res_t          res, out_res_r;
  logic                       res_valid, res_ready, out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= gpf_pkg::SIZE_RESET;
      cols_r <= gpf_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        gpf_pkg::REG_ROWS_IN_USE: rows_r <= cfg_wdata;
        gpf_pkg::REG_COLS_IN_USE: cols_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign size.nr = gpf_pkg::clamp_size(rows_r, gpf_pkg::SIZE_W'(gpf_pkg::MAX_ROWS));
  assign size.nc = gpf_pkg::clamp_size(cols_r, gpf_pkg::SIZE_W'(gpf_pkg::MAX_COLS));

  gpf_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .size      (size),
    .in_ch     (in_ch),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: refill when empty or when the held word leaves this cycle.
  assign res_ready = !out_vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.peak_found = out_res_r.found;
  assign out_ch.peak_row   = out_res_r.row;
  assign out_ch.peak_col   = out_res_r.col;

endmodule

// ===== dv/grid_peak_finder_tb.sv =====
// Self-checking testbench for grid_peak_finder: directed table, then random grids per size setting.
// Depends on gpf_pkg, gpf_in_if, gpf_out_if and the grid_peak_finder RTL.
`timescale 1ns / 1ps

module grid_peak_finder_tb;

  localparam int SETTLE_CYCLES = 7 * (gpf_pkg::MAX_ROWS + 5) + 20;
  localparam int HOLD_CYCLES   = 1500;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int NUM_PHASES    = 10;

  // Raw register values per phase; zero and 127 probe the clamp.
  localparam int PH_ROWS  [NUM_PHASES] = '{4, 127, 2, 1, 64, 0, 8, 5, 1, 3};
  localparam int PH_COLS  [NUM_PHASES] = '{4, 2, 127, 64, 1, 7, 8, 3, 1, 127};
  localparam int PH_WORDS [NUM_PHASES] = '{200, 256, 256, 128, 128, 105, 192, 120, 80, 1};

  typedef enum int {GRID_RANDOM, GRID_TIES, GRID_FLAT, GRID_PLANTED, GRID_RAMP} grid_kind_t;

  typedef struct packed {
    logic                          is_cfg;
    logic [gpf_pkg::CFG_IDX_W-1:0] idx;
    logic [gpf_pkg::CFG_W-1:0]     wdata;
    logic [gpf_pkg::CELL_W-1:0]    value;
    logic                          last;
    logic                          fixed;
    gpf_pkg::gpf_res_t             known;
  } step_t;

  logic clk;
  logic rst_n;
  logic                          cfg_we;
  logic [gpf_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [gpf_pkg::CFG_W-1:0]     cfg_wdata;

  gpf_in_if  in_ch ();
  gpf_out_if out_ch ();

  grid_peak_finder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: own copy of the grid, load position and sizes.
  logic [gpf_pkg::CELL_W-1:0] grid_mem [gpf_pkg::STORE_DEPTH];
  int                         load_ptr     = 0;
  int                         loaded_upto  = 0;  // cells 0..loaded_upto-1 written since reset
  logic [gpf_pkg::CFG_W-1:0]  size_rows    = gpf_pkg::CFG_W'(64);
  logic [gpf_pkg::CFG_W-1:0]  size_cols    = gpf_pkg::CFG_W'(64);
  gpf_pkg::gpf_res_t          pending_peaks [$];

  int  snd_idle_pct    = 0;
  int  rcv_stall_pct   = 0;
  bit  hold_req        = 0;
  int  mismatches      = 0;
  int  words_sent      = 0;
  int  searches_seen   = 0;
  int  failed_searches = 0;
  int  cycle_count     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic int eff_size(input logic [gpf_pkg::CFG_W-1:0] v, input int maxv);
    int n;
    n = int'(v);
    if (n < 1) n = 1;
    if (n > maxv) n = maxv;
    return n;
  endfunction

  function automatic int cell_at(input int r, input int c, input int nc);
    return int'(grid_mem[r * nc + c]);
  endfunction

  // Store one word, and on the last cell run the column binary search.
  function automatic void predict_cell(input logic [gpf_pkg::CELL_W-1:0] value,
                                       input logic last, output logic produced,
                                       output gpf_pkg::gpf_res_t res);
    int nr, nc, lo, hi, mid, best, v, left, right;
    bit searching;
    nr = eff_size(size_rows, gpf_pkg::MAX_ROWS);
    nc = eff_size(size_cols, gpf_pkg::MAX_COLS);
    res = '0;
    produced = 1'b0;
    if (load_ptr < nr * nc) begin
      grid_mem[load_ptr] = value;
      load_ptr++;
      if (load_ptr > loaded_upto) loaded_upto = load_ptr;
    end
    if (!last) return;
    lo = 0;
    hi = nc - 1;
    searching = 1'b1;
    while (searching && lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      best = 0;
      for (int r = 1; r < nr; r++) begin
        if (cell_at(r, mid, nc) > cell_at(best, mid, nc)) best = r;
      end
      v = cell_at(best, mid, nc);
      left = (mid >= 1) ? cell_at(best, mid - 1, nc) : -1;
      right = (mid + 1 < nc) ? cell_at(best, mid + 1, nc) : -1;
      if (v > left && v > right) begin
        res.found = 1'b1;
        res.row = gpf_pkg::POS_W'(best);
        res.col = gpf_pkg::POS_W'(mid);
        searching = 1'b0;
      end else if (v < left) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    load_ptr = 0;
    produced = 1'b1;
  endfunction

  task automatic check_peak();
    gpf_pkg::gpf_res_t want;
    if (pending_peaks.size() == 0) begin
      $error("result with nothing pending: found=%0d row=%0d col=%0d",
             out_ch.peak_found, out_ch.peak_row, out_ch.peak_col);
      mismatches++;
    end else begin
      want = pending_peaks.pop_front();
      searches_seen++;
      if (!want.found) failed_searches++;
      if (out_ch.peak_found !== want.found) begin
        $error("peak_found: expected %0d, got %0d", want.found, out_ch.peak_found);
        mismatches++;
      end
      if (out_ch.peak_row !== want.row) begin
        $error("peak_row: expected %0d, got %0d", want.row, out_ch.peak_row);
        mismatches++;
      end
      if (out_ch.peak_col !== want.col) begin
        $error("peak_col: expected %0d, got %0d", want.col, out_ch.peak_col);
        mismatches++;
      end
    end
  endtask

  // Result side: check accepted words, then pick ready for the next edge.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) check_peak();
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  task automatic send_cell(input logic [gpf_pkg::CELL_W-1:0] value, input logic last,
                           input logic fixed, input gpf_pkg::gpf_res_t known);
    logic              produced;
    gpf_pkg::gpf_res_t res;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cell_value <= value;
    in_ch.last_cell  <= last;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    predict_cell(value, last, produced, res);
    if (produced) pending_peaks.push_back(fixed ? known : res);
  endtask

  // Drop valid after the last accepted word and move to the next edge.
  task automatic stop_cells();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_peaks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [gpf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gpf_pkg::CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      gpf_pkg::REG_ROWS_IN_USE: size_rows = value;
      gpf_pkg::REG_COLS_IN_USE: size_cols = value;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // One job: a grid of the given shape, sometimes cut short or padded past the end.
  task automatic send_grid(input int nr, input int nc, inout int sent);
    grid_kind_t                 kind;
    int                         total, len, roll, pr, pc, r, c;
    logic [gpf_pkg::CELL_W-1:0] flat_val, w;
    bit                         rising;
    kind = grid_kind_t'($urandom_range(0, 4));
    total = nr * nc;
    len = total;
    roll = $urandom_range(9);
    if (roll == 0 && total >= 2 && loaded_upto >= total) begin
      len = $urandom_range(1, total - 1);
    end else if (roll == 1) begin
      len = total + $urandom_range(1, 4);
    end
    pr = $urandom_range(1) ? nr - 1 : $urandom_range(0, nr - 1);
    pc = $urandom_range(1) ? nc - 1 : $urandom_range(0, nc - 1);
    flat_val = gpf_pkg::CELL_W'($urandom);
    rising = ($urandom_range(1) == 1);
    for (int i = 0; i < len; i++) begin
      r = i / nc;
      c = i % nc;
      if (i >= total) begin
        w = gpf_pkg::CELL_W'($urandom);
      end else begin
        case (kind)
          GRID_TIES:    w = gpf_pkg::CELL_W'($urandom_range(0, 2));
          GRID_FLAT:    w = flat_val;
          GRID_PLANTED: w = (r == pr && c == pc)
                            ? gpf_pkg::CELL_W'(16'hFFFF - $urandom_range(0, 15))
                            : gpf_pkg::CELL_W'($urandom_range(0, 999));
          GRID_RAMP:    w = gpf_pkg::CELL_W'((rising ? c : nc - 1 - c) * 900
                                             + $urandom_range(0, 899));
          default:      w = gpf_pkg::CELL_W'($urandom);
        endcase
      end
      send_cell(w, i == len - 1, 1'b0, '0);
      sent++;
    end
  endtask

  function automatic step_t cfg_row(input logic [gpf_pkg::CFG_IDX_W-1:0] idx,
                                    input int value);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.wdata = gpf_pkg::CFG_W'(value);
    return s;
  endfunction

  function automatic step_t cell_row(input int value, input logic last);
    step_t s;
    s = '0;
    s.value = gpf_pkg::CELL_W'(value);
    s.last = last;
    return s;
  endfunction

  function automatic step_t known_row(input int value, input logic found, input int row,
                                      input int col);
    step_t s;
    s = cell_row(value, 1'b1);
    s.fixed = 1'b1;
    s.known.found = found;
    s.known.row = gpf_pkg::POS_W'(row);
    s.known.col = gpf_pkg::POS_W'(col);
    return s;
  endfunction

  initial begin
    step_t directed [$];
    int    sent, jobs;

    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.cell_value = '0;
    in_ch.last_cell  = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed = '{
      // single cell, both value extremes
      cfg_row(gpf_pkg::REG_ROWS_IN_USE, 1), cfg_row(gpf_pkg::REG_COLS_IN_USE, 1),
      known_row(16'hFFFF, 1'b1, 0, 0),
      known_row(0, 1'b1, 0, 0),
      // zero sizes act as one
      cfg_row(gpf_pkg::REG_ROWS_IN_USE, 0), cfg_row(gpf_pkg::REG_COLS_IN_USE, 0),
      known_row(16'h5A5A, 1'b1, 0, 0),
      // equal neighbors push the search right until it fails
      cfg_row(gpf_pkg::REG_ROWS_IN_USE, 1), cfg_row(gpf_pkg::REG_COLS_IN_USE, 3),
      cell_row(7, 1'b0), cell_row(7, 1'b0), known_row(7, 1'b0, 0, 0),
      // words past the grid are dropped; the flagged one still starts the search
      cell_row(1, 1'b0), cell_row(2, 1'b0), cell_row(3, 1'b0), cell_row(9, 1'b0),
      known_row(16'hFFFF, 1'b1, 0, 2),
      // short grid keeps the older cells
      cell_row(5, 1'b1),
      // first of two equal column maxima wins
      cfg_row(gpf_pkg::REG_ROWS_IN_USE, 3), cfg_row(gpf_pkg::REG_COLS_IN_USE, 1),
      cell_row(4, 1'b0), cell_row(9, 1'b0), known_row(9, 1'b1, 1, 0),
      cfg_row(gpf_pkg::REG_ROWS_IN_USE, 2), cfg_row(gpf_pkg::REG_COLS_IN_USE, 2),
      cell_row(1, 1'b0), cell_row(5, 1'b0), cell_row(3, 1'b0), cell_row(2, 1'b1)
    };

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        stop_cells();
        wait_drained();
        write_reg(directed[i].idx, directed[i].wdata);
      end else begin
        send_cell(directed[i].value, directed[i].last, directed[i].fixed, directed[i].known);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      stop_cells();
      wait_drained();
      write_reg(gpf_pkg::REG_ROWS_IN_USE, gpf_pkg::CFG_W'(PH_ROWS[p]));
      write_reg(gpf_pkg::REG_COLS_IN_USE, gpf_pkg::CFG_W'(PH_COLS[p]));
      case (p % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 48; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 48; end
        default: begin snd_idle_pct = 8; rcv_stall_pct = 8; end
      endcase
      // long result hold-off while grids keep coming: fills the block
      if (p == 0) hold_req = 1'b1;
      sent = 0;
      jobs = 0;
      while (sent < PH_WORDS[p]) begin
        send_grid(eff_size(gpf_pkg::CFG_W'(PH_ROWS[p]), gpf_pkg::MAX_ROWS),
                  eff_size(gpf_pkg::CFG_W'(PH_COLS[p]), gpf_pkg::MAX_COLS), sent);
        jobs++;
        if (jobs == 1 && p != 0) begin
          stop_cells();
          while (pending_peaks.size() != 0) @(posedge clk);
        end
      end
    end

    stop_cells();
    wait_drained();
    $display("sent %0d grid words over %0d size settings plus the directed table",
             words_sent, NUM_PHASES);
    $display("checked %0d searches, %0d of them without a peak", searches_seen,
             failed_searches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
